FILE: sv/cdv_pkg.sv
// shared types and constants for the coap datagram validator
`default_nettype none

package cdv_pkg;

   localparam int MAX_TOKEN   = 8;
   localparam int LEN_BITS    = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [LEN_BITS-1:0] MAX_COUNT = '1;

   localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
   localparam logic [3:0]  NIBBLE_EXT1    = 4'd13;
   localparam logic [3:0]  NIBBLE_EXT2    = 4'd14;
   localparam logic [3:0]  NIBBLE_BAD     = 4'd15;
   localparam logic [16:0] EXT1_BASE      = 17'd13;
   localparam logic [16:0] EXT2_BASE      = 17'd269;
   localparam logic [1:0]  COAP_VERSION   = 2'd1;
   localparam logic [15:0] MIN_LENGTH     = 16'd4;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FORMAT  = 2'd1;
   localparam logic [1:0] STATUS_VERSION = 2'd2;

   localparam logic KIND_OPTION  = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // one queue entry: an option record, a verdict or both from the same byte
   typedef struct packed {
      logic        rec_valid;
      logic        ver_valid;
      logic [1:0]  msg_type;
      logic [7:0]  code;
      logic [15:0] msg_ident;
      logic [3:0]  token_len;
      logic [31:0] opt_num;
      logic [16:0] opt_len;
      logic [1:0]  status;
      logic [15:0] pay_offset;
      logic [15:0] pay_len;
   } evt_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } qstat_type;

endpackage

`default_nettype wire

FILE: sv/cdv_parser.sv
// front end: byte parser that pushes a queue entry for each option record and each verdict
`default_nettype none

module cdv_parser (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      data_byte,
   input  logic            last_byte,
   output logic            push,
   output cdv_pkg::evt_type evt
);
   import cdv_pkg::*;

   typedef enum logic [3:0] {
      PH_H0, PH_H1, PH_H2, PH_H3, PH_TOKEN, PH_OPT, PH_DX1, PH_DX2A, PH_DX2B,
      PH_LX1, PH_LX2A, PH_LX2B, PH_VALUE, PH_PAYLOAD, PH_SKIP
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [LEN_BITS-1:0] count_ff, count_in;
   logic [1:0]          ver_ff, ver_in;
   logic [1:0]          type_ff, type_in;
   logic [7:0]          code_ff, code_in;
   logic [15:0]         msgid_ff, msgid_in;
   logic [3:0]          tkl_ff, tkl_in;
   logic [31:0]         optnum_ff, optnum_in;
   logic [3:0]          lnib_ff, lnib_in;
   logic [7:0]          ext_ff, ext_in;
   logic [16:0]         rem_ff, rem_in;
   logic [1:0]          err_ff, err_in;
   logic [15:0]         pstart_ff, pstart_in;

   always_comb begin
      logic        do_add;
      logic        do_lstage;
      logic        do_finish;
      logic        rec;
      logic [16:0] add_val;
      logic [16:0] fin_len;
      logic [32:0] sum;
      logic [16:0] rem_dec;
      logic [1:0]  status;
      logic [15:0] off;
      logic [15:0] size;

      do_add    = 1'b0;
      do_lstage = 1'b0;
      do_finish = 1'b0;
      rec       = 1'b0;
      add_val   = '0;
      fin_len   = '0;
      sum       = '0;
      rem_dec   = '0;
      status    = STATUS_FORMAT;
      off       = '0;
      size      = '0;

      phase_in  = phase_ff;
      count_in  = count_ff;
      ver_in    = ver_ff;
      type_in   = type_ff;
      code_in   = code_ff;
      msgid_in  = msgid_ff;
      tkl_in    = tkl_ff;
      optnum_in = optnum_ff;
      lnib_in   = lnib_ff;
      ext_in    = ext_ff;
      rem_in    = rem_ff;
      err_in    = err_ff;
      pstart_in = pstart_ff;

      if (count_ff == MAX_COUNT) begin
         // over length: first error wins, count saturates
         if (err_ff == STATUS_OK) err_in = STATUS_FORMAT;
         phase_in = PH_SKIP;
      end else begin
         count_in = count_ff + 1'b1;
         unique case (phase_ff)
            PH_H0: begin
               ver_in   = data_byte[7:6];
               type_in  = data_byte[5:4];
               tkl_in   = data_byte[3:0];
               phase_in = PH_H1;
            end
            PH_H1: begin
               code_in  = data_byte;
               phase_in = PH_H2;
            end
            PH_H2: begin
               msgid_in = {data_byte, 8'h00};
               phase_in = PH_H3;
            end
            PH_H3: begin
               msgid_in = {msgid_ff[15:8], data_byte};
               if (ver_ff != COAP_VERSION) begin
                  if (err_ff == STATUS_OK) err_in = STATUS_VERSION;
                  phase_in = PH_SKIP;
               end else if (32'(tkl_ff) > 32'(MAX_TOKEN)) begin
                  if (err_ff == STATUS_OK) err_in = STATUS_FORMAT;
                  phase_in = PH_SKIP;
               end else if (tkl_ff == 4'd0) begin
                  phase_in = PH_OPT;
               end else begin
                  rem_in   = {13'd0, tkl_ff};
                  phase_in = PH_TOKEN;
               end
            end
            PH_TOKEN, PH_VALUE: begin
               rem_dec = (rem_ff != 17'd0) ? rem_ff - 1'b1 : rem_ff;
               rem_in  = rem_dec;
               if (rem_dec == 17'd0) phase_in = PH_OPT;
            end
            PH_OPT: begin
               if (data_byte == PAYLOAD_MARKER) begin
                  if (last_byte) begin
                     if (err_ff == STATUS_OK) err_in = STATUS_FORMAT;
                     phase_in = PH_SKIP;
                  end else begin
                     pstart_in = count_in;
                     phase_in  = PH_PAYLOAD;
                  end
               end else if (data_byte[7:4] == NIBBLE_BAD ||
                            data_byte[3:0] == NIBBLE_BAD) begin
                  if (err_ff == STATUS_OK) err_in = STATUS_FORMAT;
                  phase_in = PH_SKIP;
               end else begin
                  lnib_in = data_byte[3:0];
                  if (data_byte[7:4] == NIBBLE_EXT1) begin
                     phase_in = PH_DX1;
                  end else if (data_byte[7:4] == NIBBLE_EXT2) begin
                     phase_in = PH_DX2A;
                  end else begin
                     do_add    = 1'b1;
                     add_val   = {13'd0, data_byte[7:4]};
                     do_lstage = 1'b1;
                  end
               end
            end
            PH_DX1: begin
               do_add    = 1'b1;
               add_val   = EXT1_BASE + {9'd0, data_byte};
               do_lstage = 1'b1;
            end
            PH_DX2A: begin
               ext_in   = data_byte;
               phase_in = PH_DX2B;
            end
            PH_DX2B: begin
               do_add    = 1'b1;
               add_val   = EXT2_BASE + {1'b0, ext_ff, data_byte};
               do_lstage = 1'b1;
            end
            PH_LX1: begin
               do_finish = 1'b1;
               fin_len   = EXT1_BASE + {9'd0, data_byte};
            end
            PH_LX2A: begin
               ext_in   = data_byte;
               phase_in = PH_LX2B;
            end
            PH_LX2B: begin
               do_finish = 1'b1;
               fin_len   = EXT2_BASE + {1'b0, ext_ff, data_byte};
            end
            PH_PAYLOAD, PH_SKIP: begin
            end
            default: begin
            end
         endcase
      end

      // option number saturates at all ones
      if (do_add) begin
         sum       = {1'b0, optnum_ff} + {16'd0, add_val};
         optnum_in = sum[32] ? '1 : sum[31:0];
      end

      if (do_lstage) begin
         if (lnib_in == NIBBLE_EXT1) begin
            phase_in = PH_LX1;
         end else if (lnib_in == NIBBLE_EXT2) begin
            phase_in = PH_LX2A;
         end else begin
            do_finish = 1'b1;
            fin_len   = {13'd0, lnib_in};
         end
      end

      if (do_finish) begin
         rec = 1'b1;
         if (fin_len == 17'd0) begin
            phase_in = PH_OPT;
         end else begin
            rem_in   = fin_len;
            phase_in = PH_VALUE;
         end
      end

      if (count_in < MIN_LENGTH) begin
         status = STATUS_FORMAT;
      end else if (err_in != STATUS_OK) begin
         status = err_in;
      end else if (phase_in == PH_OPT) begin
         status = STATUS_OK;
         off    = count_in;
      end else if (phase_in == PH_PAYLOAD) begin
         status = STATUS_OK;
         off    = pstart_in;
         size   = count_in - pstart_in;
      end

      evt.rec_valid  = rec;
      evt.ver_valid  = last_byte;
      evt.msg_type   = type_in;
      evt.code       = code_in;
      evt.msg_ident  = msgid_in;
      evt.token_len  = tkl_in;
      evt.opt_num    = optnum_in;
      evt.opt_len    = fin_len;
      evt.status     = status;
      evt.pay_offset = off;
      evt.pay_len    = size;
      push           = accept && (rec || last_byte);

      // verdict closes the datagram, back to the first header byte
      if (last_byte) begin
         phase_in  = PH_H0;
         count_in  = '0;
         ver_in    = '0;
         type_in   = '0;
         code_in   = '0;
         msgid_in  = '0;
         tkl_in    = '0;
         optnum_in = '0;
         lnib_in   = '0;
         ext_in    = '0;
         rem_in    = '0;
         err_in    = STATUS_OK;
         pstart_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_H0;
         count_ff  <= '0;
         ver_ff    <= '0;
         type_ff   <= '0;
         code_ff   <= '0;
         msgid_ff  <= '0;
         tkl_ff    <= '0;
         optnum_ff <= '0;
         lnib_ff   <= '0;
         ext_ff    <= '0;
         rem_ff    <= '0;
         err_ff    <= STATUS_OK;
         pstart_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         ver_ff    <= ver_in;
         type_ff   <= type_in;
         code_ff   <= code_in;
         msgid_ff  <= msgid_in;
         tkl_ff    <= tkl_in;
         optnum_ff <= optnum_in;
         lnib_ff   <= lnib_in;
         ext_ff    <= ext_in;
         rem_ff    <= rem_in;
         err_ff    <= err_in;
         pstart_ff <= pstart_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/cdv_event_queue.sv
// short queue of parsed entries between the parser and the emitter
`default_nettype none

module cdv_event_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cdv_pkg::evt_type  push_evt,
   input  logic              deq,
   output cdv_pkg::evt_type  head,
   output cdv_pkg::qstat_type stat
);
   import cdv_pkg::*;

   evt_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ff, wr_in;
   logic [QUEUE_AW-1:0] rd_ff, rd_in;
   logic [QUEUE_AW:0]   cnt_ff, cnt_in;
   logic                do_push;
   logic                do_deq;

   assign stat.not_empty = (cnt_ff != '0);
   assign stat.full      = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign do_push        = push && !stat.full;
   assign do_deq         = deq && stat.not_empty;
   assign head           = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_deq ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_deq) cnt_in = cnt_ff + 1'b1;
      if (!do_push && do_deq) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_evt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/cdv_emitter.sv
// back end: splits each queue entry into option record and verdict results
`default_nettype none

module cdv_emitter (
   input  logic               clock,
   input  logic               reset,
   input  cdv_pkg::evt_type   head,
   input  cdv_pkg::qstat_type stat,
   input  logic               pop,
   output logic               deq,
   output logic               empty,
   output logic               kind,
   output logic [1:0]         status,
   output logic [1:0]         msg_type,
   output logic [7:0]         code,
   output logic [15:0]        msg_ident,
   output logic [3:0]         token_len,
   output logic [31:0]        opt_num,
   output logic [16:0]        opt_len,
   output logic [15:0]        pay_offset,
   output logic [15:0]        pay_len,
   output logic               last_result
);
   import cdv_pkg::*;

   // set once the record half of a two-result entry has gone out
   logic rec_sent_ff, rec_sent_in;
   logic show_rec;
   logic take;

   assign empty    = !stat.not_empty;
   assign take     = pop && stat.not_empty;
   assign show_rec = head.rec_valid && !rec_sent_ff;

   assign kind        = show_rec ? KIND_OPTION : KIND_VERDICT;
   assign status      = show_rec ? STATUS_OK : head.status;
   assign msg_type    = head.msg_type;
   assign code        = head.code;
   assign msg_ident   = head.msg_ident;
   assign token_len   = head.token_len;
   assign opt_num     = show_rec ? head.opt_num : '0;
   assign opt_len     = show_rec ? head.opt_len : '0;
   assign pay_offset  = show_rec ? '0 : head.pay_offset;
   assign pay_len     = show_rec ? '0 : head.pay_len;
   assign last_result = !show_rec;

   always_comb begin
      rec_sent_in = rec_sent_ff;
      deq         = 1'b0;
      if (take) begin
         if (show_rec && head.ver_valid) begin
            rec_sent_in = 1'b1;
         end else begin
            rec_sent_in = 1'b0;
            deq         = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_sent_ff <= 1'b0;
      end else begin
         rec_sent_ff <= rec_sent_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/coap_datagram_validator.sv
// top level of the streaming coap datagram validator
//
//   channel   ports                           direction  handshake
//   request   req_data_byte, req_last_byte    in         req_push / req_full
//   response  rsp_kind .. rsp_last_result     out        rsp_empty / rsp_pop
//
// one byte is taken per cycle while req_full is low; the parser updates its state in that cycle
// and writes at most one entry into a four-deep queue.
// a byte that ends an option header on the final byte yields two results,
// so the emitter spends two pops on that entry.
// req_full rises only when the queue holds four entries; a stalled pop
// side therefore stops requests after four pending entries.
// reset is synchronous and clears the parser state and the queue.
`default_nettype none

module coap_datagram_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_msg_type,
   output logic [7:0]  rsp_code,
   output logic [15:0] rsp_msg_ident,
   output logic [3:0]  rsp_token_len,
   output logic [31:0] rsp_opt_num,
   output logic [16:0] rsp_opt_len,
   output logic [15:0] rsp_pay_offset,
   output logic [15:0] rsp_pay_len,
   output logic        rsp_last_result
);
   import cdv_pkg::*;

   evt_type   push_evt;
   evt_type   head;
   qstat_type stat;
   logic      push;
   logic      deq;
   logic      accept;

   assign req_full = stat.full;
   assign accept   = req_push && !stat.full;

   cdv_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .push      (push),
      .evt       (push_evt)
   );

   cdv_event_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_evt (push_evt),
      .deq      (deq),
      .head     (head),
      .stat     (stat)
   );

   cdv_emitter u_emitter (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .stat        (stat),
      .pop         (rsp_pop),
      .deq         (deq),
      .empty       (rsp_empty),
      .kind        (rsp_kind),
      .status      (rsp_status),
      .msg_type    (rsp_msg_type),
      .code        (rsp_code),
      .msg_ident   (rsp_msg_ident),
      .token_len   (rsp_token_len),
      .opt_num     (rsp_opt_num),
      .opt_len     (rsp_opt_len),
      .pay_offset  (rsp_pay_offset),
      .pay_len     (rsp_pay_len),
      .last_result (rsp_last_result)
   );

endmodule

`default_nettype wire

FILE: sv/cdv_checker.sv
// port level checks for the coap datagram validator
`default_nettype none

module cdv_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_kind,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_opt_num,
   input logic [16:0] rsp_opt_len,
   input logic [15:0] rsp_pay_offset,
   input logic [15:0] rsp_pay_len,
   input logic        rsp_last_result
);
   import cdv_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("results present right after reset");

   a_last_is_verdict: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_kind == rsp_last_result))
      else $error("last flag does not match verdict kind");

   a_record_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_OPTION) |->
         (rsp_status == STATUS_OK && rsp_pay_offset == '0 &&
          rsp_pay_len == '0))
      else $error("option record carries verdict fields");

   a_verdict_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_VERDICT) |->
         (rsp_opt_num == '0 && rsp_opt_len == '0 &&
          rsp_status != 2'd3))
      else $error("verdict carries option fields or bad status");

   a_error_no_payload: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_VERDICT && rsp_status != STATUS_OK) |->
         (rsp_pay_offset == '0 && rsp_pay_len == '0))
      else $error("failed verdict reports a payload");

endmodule

bind coap_datagram_validator cdv_port_checks u_port_checks (
   .clock           (clock),
   .reset           (reset),
   .rsp_empty       (rsp_empty),
   .rsp_kind        (rsp_kind),
   .rsp_status      (rsp_status),
   .rsp_opt_num     (rsp_opt_num),
   .rsp_opt_len     (rsp_opt_len),
   .rsp_pay_offset  (rsp_pay_offset),
   .rsp_pay_len     (rsp_pay_len),
   .rsp_last_result (rsp_last_result)
);

`default_nettype wire
